FILE: hdl/chl_pkg.sv
// Shared definitions for the compacting handle list core.
// Holds sizes, operation codes and the per-cell control struct; no dependencies.
package chl_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int POS_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        KIND_PUSH         = 3'd0,
        KIND_POP          = 3'd1,
        KIND_SHIFT        = 3'd2,
        KIND_GET          = 3'd3,
        KIND_REMOVE_AT    = 3'd4,
        KIND_REMOVE_VALUE = 3'd5
    } kind_t;

    // Broadcast to every cell of the row.
    typedef struct packed {
        logic                  push;      // write key into the cell at position length
        logic                  lookup;    // select a cell this transaction
        logic                  take;      // close the gap behind the selected cell
        logic                  by_value;  // select on key match instead of target position
        logic [POS_W-1:0]      target;
        logic [CNT_W-1:0]      length;
        logic [VALUE_BITS-1:0] key;
    } cell_ctrl_t;

endpackage

FILE: hdl/chl_cell.sv
// One storage cell of the handle list row.
// Depends on chl_pkg; holds one slot, chains first-hit and takes data from its upper neighbor.
module chl_cell
(
    input  logic                           clk,
    input  logic [chl_pkg::POS_W-1:0]      pos,
    input  chl_pkg::cell_ctrl_t            ctrl,
    input  logic                           seen_in,
    input  logic [chl_pkg::VALUE_BITS-1:0] shift_data_in,
    output logic                           seen_out,
    output logic [chl_pkg::VALUE_BITS-1:0] slot,
    output logic                           hit,
    output logic [chl_pkg::VALUE_BITS-1:0] hit_value
);

    logic [chl_pkg::VALUE_BITS-1:0] slot_reg;
    logic [chl_pkg::VALUE_BITS-1:0] slot_next;
    logic                           in_use;
    logic                           match;

    assign in_use    = chl_pkg::CNT_W'(pos) < ctrl.length;
    assign match     = ctrl.by_value ? (slot_reg == ctrl.key) : (pos == ctrl.target);
    assign hit       = ctrl.lookup & in_use & match & ~seen_in;
    assign seen_out  = seen_in | hit;
    assign slot      = slot_reg;
    assign hit_value = hit ? slot_reg : '0;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.push && (chl_pkg::CNT_W'(pos) == ctrl.length))
        begin
            slot_next = ctrl.key;
        end
        else if (ctrl.take && seen_out)
        begin
            slot_next = shift_data_in;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

FILE: hdl/compacting_handle_list_core.sv
// Compacting handle list core: a row of chl_cell slots plus length and result registers.
// Depends on chl_pkg and chl_cell.
// Result: a transaction's result is registered and presented in the cycle after it is accepted.
// Throughput: one transaction per cycle unless rsp_ready stalls; the cell row updates on accept.
// Reset: rst_n clears the length and the result valid; slot contents are undefined until written.
module compacting_handle_list_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [2:0]                     kind,
    input  logic [31:0]                    value,
    input  logic [3:0]                     index,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic                           ok,
    output logic [31:0]                    result_value,
    output logic [4:0]                     count
);

    localparam int N = chl_pkg::DEPTH;

    logic                           accept;
    chl_pkg::cell_ctrl_t            ctrl;
    logic [N:0]                     seen;
    logic [chl_pkg::VALUE_BITS-1:0] slot      [N];
    logic [chl_pkg::VALUE_BITS-1:0] hit_value [N];
    logic [N-1:0]                   hit;
    logic [chl_pkg::VALUE_BITS-1:0] found_value;
    logic                           any_hit;
    logic                           ok_now;

    logic [chl_pkg::CNT_W-1:0]      length_reg;
    logic [chl_pkg::CNT_W-1:0]      length_next;
    logic                           rsp_valid_reg;
    logic                           ok_reg;
    logic [chl_pkg::VALUE_BITS-1:0] result_value_reg;
    logic [chl_pkg::CNT_W-1:0]      count_reg;

    assign req_ready = ~rsp_valid_reg | rsp_ready;
    assign accept    = req_valid & req_ready;

    always_comb
    begin
        ctrl          = '0;
        ctrl.length   = length_reg;
        ctrl.key      = value;
        ctrl.target   = index;
        case (chl_pkg::kind_t'(kind))
            chl_pkg::KIND_PUSH:
            begin
                ctrl.push = accept;
            end
            chl_pkg::KIND_POP:
            begin
                ctrl.lookup = accept;
                ctrl.take   = accept;
                ctrl.target = length_reg[chl_pkg::POS_W-1:0] - chl_pkg::POS_W'(1);
            end
            chl_pkg::KIND_SHIFT:
            begin
                ctrl.lookup = accept;
                ctrl.take   = accept;
                ctrl.target = '0;
            end
            chl_pkg::KIND_GET:
            begin
                ctrl.lookup = accept;
            end
            chl_pkg::KIND_REMOVE_AT:
            begin
                ctrl.lookup = accept;
                ctrl.take   = accept;
            end
            chl_pkg::KIND_REMOVE_VALUE:
            begin
                ctrl.lookup   = accept;
                ctrl.take     = accept;
                ctrl.by_value = 1'b1;
            end
            default:
            begin
                ctrl.push = 1'b0;
            end
        endcase
    end

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [chl_pkg::VALUE_BITS-1:0] upper;
        if (i == N - 1)
        begin : g_top
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = slot[i+1];
        end

        chl_cell u_cell
        (
            .clk           (clk),
            .pos           (chl_pkg::POS_W'(i)),
            .ctrl          (ctrl),
            .seen_in       (seen[i]),
            .shift_data_in (upper),
            .seen_out      (seen[i+1]),
            .slot          (slot[i]),
            .hit           (hit[i]),
            .hit_value     (hit_value[i])
        );
    end

    always_comb
    begin
        found_value = '0;
        for (int i = 0; i < N; i++)
        begin
            found_value = found_value | hit_value[i];
        end
    end

    assign any_hit = |hit;

    always_comb
    begin
        length_next = length_reg;
        ok_now      = 1'b0;
        case (chl_pkg::kind_t'(kind))
            chl_pkg::KIND_PUSH:
            begin
                ok_now = length_reg < chl_pkg::CNT_W'(N);
                if (ok_now)
                begin
                    length_next = length_reg + chl_pkg::CNT_W'(1);
                end
            end
            chl_pkg::KIND_POP, chl_pkg::KIND_SHIFT, chl_pkg::KIND_REMOVE_AT,
            chl_pkg::KIND_REMOVE_VALUE:
            begin
                ok_now = any_hit;
                if (any_hit)
                begin
                    length_next = length_reg - chl_pkg::CNT_W'(1);
                end
            end
            chl_pkg::KIND_GET:
            begin
                ok_now = any_hit;
            end
            default:
            begin
                ok_now = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                length_reg    <= length_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg           <= ok_now;
            result_value_reg <= found_value;
            count_reg        <= length_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign ok           = ok_reg;
    assign result_value = result_value_reg;
    assign count        = count_reg;

`ifndef ASSERT_OFF
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= chl_pkg::CNT_W'(N))
        else $error("list length above capacity");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit))
        else $error("more than one cell selected");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !ok |-> result_value == '0)
        else $error("failed transaction returned a nonzero handle");

    a_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (kind == chl_pkg::KIND_PUSH) && (length_reg == chl_pkg::CNT_W'(N))
        |=> length_reg == $past(length_reg))
        else $error("push into a full list changed the length");
`endif

endmodule

FILE: test/tb_compacting_handle_list_core.sv
// Self-checking testbench for compacting_handle_list_core: a directed table, then random
// list traffic, checked against a shadow list kept in the bench. Depends on chl_pkg and the RTL.
module tb_compacting_handle_list_core;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int SEGMENTS        = 14;
    localparam int SEGMENT_ITEMS   = 50;

    typedef struct packed {
        logic        ok;
        logic [31:0] rval;
        logic [4:0]  cnt;
    } rsp_t;

    typedef struct packed {
        logic [2:0]  k;
        logic [31:0] v;
        logic [3:0]  ix;
        logic        typed;
        rsp_t        want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [2:0]  kind;
    logic [31:0] value;
    logic [3:0]  index;
    logic        rsp_valid;
    logic        rsp_ready;
    logic        ok;
    logic [31:0] result_value;
    logic [4:0]  count;

    logic        row_typed;
    rsp_t        row_want;

    logic [31:0] handles [chl_pkg::DEPTH];
    int          handle_count;
    rsp_t        outstanding [$];
    stim_row_t   directed [$];
    int          errors;
    bit          send_gaps;
    bit          recv_idle;
    bit          hold_off_req;

    compacting_handle_list_core u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .kind         (kind),
        .value        (value),
        .index        (index),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .ok           (ok),
        .result_value (result_value),
        .count        (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    // Shadow list update for one accepted transaction.
    function automatic rsp_t apply_list_op(logic [2:0] k, logic [31:0] v, logic [3:0] ix);
        rsp_t r;
        int   pos;
        int   i;
        r   = '0;
        pos = -1;
        case (k)
            chl_pkg::KIND_PUSH:
                if (handle_count < chl_pkg::DEPTH)
                begin
                    handles[handle_count] = v;
                    handle_count++;
                    r.ok = 1'b1;
                end
            chl_pkg::KIND_POP:
                if (handle_count > 0)
                begin
                    handle_count--;
                    r.rval = handles[handle_count];
                    r.ok   = 1'b1;
                end
            chl_pkg::KIND_SHIFT:
                if (handle_count > 0)
                    pos = 0;
            chl_pkg::KIND_GET:
                if (int'(ix) < handle_count)
                begin
                    r.rval = handles[ix];
                    r.ok   = 1'b1;
                end
            chl_pkg::KIND_REMOVE_AT:
                if (int'(ix) < handle_count)
                    pos = int'(ix);
            chl_pkg::KIND_REMOVE_VALUE:
                for (i = 0; i < handle_count; i++)
                    if (pos < 0 && handles[i] == v)
                        pos = i;
            default:
                ;
        endcase
        if (pos >= 0)
        begin
            r.rval = handles[pos];
            r.ok   = 1'b1;
            for (i = pos; i + 1 < handle_count; i++)
                handles[i] = handles[i + 1];
            handle_count--;
        end
        r.cnt = handle_count[4:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
            begin
                want = apply_list_op(kind, value, index);
                if (row_typed)
                    want = row_want;
                outstanding.push_back(want);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (outstanding.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction, expected none %s%0b %s%0h %s%0d",
                             $time, "actual ok=", ok, "value=", result_value,
                             "count=", count);
                end
                else
                begin
                    want = outstanding.pop_front();
                    check_field("ok", 32'(want.ok), 32'(ok));
                    check_field("result_value", want.rval, result_value);
                    check_field("count", 32'(want.cnt), 32'(count));
                end
            end
        end
    end

    // Response side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                rsp_ready <= 1'b1;
            end
            else if (recv_idle && $urandom_range(0, 4) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                rsp_ready <= 1'b1;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    task automatic send_txn(input logic [2:0] k, input logic [31:0] v, input logic [3:0] ix,
                            input logic typed, input rsp_t want);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        value     <= v;
        index     <= ix;
        row_typed <= typed;
        row_want  <= want;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_row(logic [2:0] k, logic [31:0] v, logic [3:0] ix, logic typed,
                           logic ok_w, logic [31:0] val_w, logic [4:0] cnt_w);
        stim_row_t row;
        row.k         = k;
        row.v         = v;
        row.ix        = ix;
        row.typed     = typed;
        row.want.ok   = ok_w;
        row.want.rval = val_w;
        row.want.cnt  = cnt_w;
        directed.push_back(row);
    endtask

    initial
    begin
        logic [2:0]  k;
        logic [31:0] v;
        logic [3:0]  ix;
        int          push_pct;
        int          seg;
        int          n;
        int          r;
        rsp_t        none;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        kind         = '0;
        value        = '0;
        index        = '0;
        row_typed    = 1'b0;
        row_want     = '0;
        none         = '0;
        errors       = 0;
        handle_count = 0;
        send_gaps    = 1'b1;
        recv_idle    = 1'b1;
        hold_off_req = 1'b0;

        //      kind                        value          index typed ok  result  count
        add_row(chl_pkg::KIND_POP,          32'h0,         4'd0,  1, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_SHIFT,        32'h0,         4'd0,  1, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_GET,          32'h0,         4'd0,  1, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_REMOVE_AT,    32'h0,         4'd15, 1, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_REMOVE_VALUE, 32'h0,         4'd0,  1, 0, 32'h0,         5'd0);
        add_row(KIND_SPARE_6,               32'h0,         4'd0,  1, 0, 32'h0,         5'd0);
        add_row(KIND_SPARE_7,               32'hFFFF_FFFF, 4'd15, 1, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_PUSH,         32'hFFFF_FFFF, 4'd15, 1, 1, 32'h0,         5'd1);
        add_row(chl_pkg::KIND_PUSH,         32'h0,         4'd0,  1, 1, 32'h0,         5'd2);
        add_row(chl_pkg::KIND_PUSH,         32'h1234_5678, 4'd7,  1, 1, 32'h0,         5'd3);
        add_row(chl_pkg::KIND_PUSH,         32'h0,         4'd0,  1, 1, 32'h0,         5'd4);
        add_row(chl_pkg::KIND_GET,          32'h0,         4'd15, 1, 0, 32'h0,         5'd4);
        add_row(chl_pkg::KIND_GET,          32'h0,         4'd4,  1, 0, 32'h0,         5'd4);
        add_row(chl_pkg::KIND_GET,          32'h0,         4'd0,  1, 1, 32'hFFFF_FFFF, 5'd4);
        add_row(chl_pkg::KIND_REMOVE_VALUE, 32'h0,         4'd0,  1, 1, 32'h0,         5'd3);
        add_row(chl_pkg::KIND_REMOVE_VALUE, 32'hDEAD_BEEF, 4'd0,  1, 0, 32'h0,         5'd3);
        add_row(chl_pkg::KIND_GET,          32'h0,         4'd1,  0, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_REMOVE_AT,    32'h0,         4'd0,  0, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_SHIFT,        32'h0,         4'd0,  0, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_POP,          32'h0,         4'd0,  0, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_POP,          32'h0,         4'd0,  1, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_PUSH,         32'h8000_0000, 4'd0,  0, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_PUSH,         32'h7FFF_FFFF, 4'd0,  0, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_REMOVE_AT,    32'h0,         4'd1,  0, 0, 32'h0,         5'd0);
        add_row(chl_pkg::KIND_REMOVE_AT,    32'h0,         4'd0,  0, 0, 32'h0,         5'd0);

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_txn(directed[i].k, directed[i].v, directed[i].ix, directed[i].typed,
                     directed[i].want);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg % 4)
                0:       push_pct = 80;
                2:       push_pct = 15;
                default: push_pct = 45;
            endcase
            send_gaps = (seg < SEGMENTS - 2) && (seg % 3 != 2);
            recv_idle = (seg < SEGMENTS - 2) && (seg % 3 != 1);
            if (seg == 3)
                hold_off_req = 1'b1;
            if (seg == 6 || seg == 9)
            begin
                req_valid <= 1'b0;
                do
                    @(negedge clk);
                while (outstanding.size() != 0);
            end
            n = 0;
            while (n < SEGMENT_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    k = ($urandom_range(0, 1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7;
                else if (r < 2 + push_pct)
                    k = chl_pkg::KIND_PUSH;
                else
                    k = 3'($urandom_range(int'(chl_pkg::KIND_POP),
                                          int'(chl_pkg::KIND_REMOVE_VALUE)));
                case ($urandom_range(0, 3))
                    0: v = $urandom;
                    1: v = $urandom_range(0, 7);
                    2: v = (handle_count > 0) ? handles[$urandom_range(0, handle_count - 1)]
                                              : $urandom;
                    default:
                        case ($urandom_range(0, 3))
                            0:       v = 32'h0;
                            1:       v = 32'hFFFF_FFFF;
                            2:       v = 32'h8000_0000;
                            default: v = 32'h7FFF_FFFF;
                        endcase
                endcase
                if (k == chl_pkg::KIND_REMOVE_VALUE && handle_count > 0
                    && $urandom_range(0, 3) != 0)
                    v = handles[$urandom_range(0, handle_count - 1)];
                if (handle_count > 0 && $urandom_range(0, 9) < 7)
                    ix = 4'($urandom_range(0, handle_count - 1));
                else
                    ix = 4'($urandom_range(0, 15));
                send_txn(k, v, ix, 1'b0, none);
                if (k != KIND_SPARE_6 && k != KIND_SPARE_7)
                    n++;
            end
        end

        req_valid <= 1'b0;
        while (outstanding.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        if (errors == 0 && outstanding.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
